// ===== hdl/shader_source_minifier_macros.svh =====
// assertion macros used by the checker
`ifndef SHADER_SOURCE_MINIFIER_MACROS_SVH
`define SHADER_SOURCE_MINIFIER_MACROS_SVH

// checked outside reset
`define SSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define SSM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ssm_pkg.sv =====
`default_nettype none

package ssm_pkg;

  localparam int CHAR_W  = 8;
  localparam int RES_MAX = 3;
  localparam int CNT_W   = 2;
  localparam int IDX_W   = 2;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2f;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2a;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5c;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7b;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7d;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3b;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3a;
  localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3d;
  localparam logic [CHAR_W-1:0] CH_APOS   = 8'h27;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;

  typedef enum logic [5:0] {
    M_NORMAL = 6'b000001,
    M_AFTER  = 6'b000010,
    M_LINE   = 6'b000100,
    M_BLOCK  = 6'b001000,
    M_PRE    = 6'b010000,
    M_PCMT   = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } res_t;

  function automatic logic is_line_break(input logic [CHAR_W-1:0] b);
    return (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic logic is_blank(input logic [CHAR_W-1:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || is_line_break(b);
  endfunction

  function automatic logic wants_space(input logic [CHAR_W-1:0] b);
    return !(b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_LPAREN, CH_RPAREN,
                       CH_LBRACE, CH_RBRACE, CH_SEMI, CH_COLON, CH_EQUAL,
                       CH_APOS, CH_QUOTE});
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ssm_stream_if.sv =====
`default_nettype none

interface ssm_in_if import ssm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] in_char;
  logic              in_end;

  modport source (output valid, output in_char, output in_end, input ready);
  modport sink   (input valid, input in_char, input in_end, output ready);
endinterface

interface ssm_out_if import ssm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              out_end;

  modport source (output valid, output out_char, output out_end, input ready);
  modport sink   (input valid, input out_char, input out_end, output ready);
endinterface

`default_nettype wire

// ===== hdl/shader_source_minifier.sv =====
// results of a byte are registered and offered from the cycle after its input transfer
// throughput: one byte per cycle while each byte yields at most one result and the
//   output is ready; a byte yielding two or three results holds the input until
//   the three-entry result buffer drains to its last result
// reset: synchronous, clears scan mode, previous byte and held byte, empties result buffer
`default_nettype none

module shader_source_minifier import ssm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ssm_in_if.sink     src,
  ssm_out_if.source  dst
);

  mode_t             mode;
  mode_t             mode_next;
  logic [CHAR_W-1:0] prev;
  logic [CHAR_W-1:0] held_char;
  logic              held_valid;
  logic [CHAR_W-1:0] held_char_next;
  logic              held_valid_next;

  res_t              res [RES_MAX];
  res_t              res_new [RES_MAX];
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_new;

  logic [CHAR_W-1:0] c;
  logic              retract;
  logic [1:0]        n_emit;
  logic [CHAR_W-1:0] b1;
  logic [CHAR_W-1:0] b2;
  logic              hv_kept;
  logic              accept;
  logic              pop;

  assign c = src.in_char;

  // decode one source byte into retract and up to two emitted bytes
  always_comb begin
    retract   = 1'b0;
    n_emit    = 2'd0;
    b1        = c;
    b2        = CH_HASH;
    mode_next = mode;
    case (mode)
      M_LINE: begin
        if (is_line_break(c)) mode_next = M_NORMAL;
      end
      M_BLOCK: begin
        if (prev == CH_STAR && c == CH_SLASH) mode_next = M_AFTER;
      end
      M_PRE: begin
        if (is_line_break(c) && prev != CH_BSLASH) begin
          n_emit    = 2'd1;
          mode_next = M_NORMAL;
        end else if (c == CH_SLASH && prev == CH_SLASH) begin
          retract   = 1'b1;
          mode_next = M_PCMT;
        end else begin
          n_emit = 2'd1;
        end
      end
      M_PCMT: begin
        if (is_line_break(c)) begin
          n_emit    = 2'd1;
          mode_next = M_NORMAL;
        end
      end
      M_NORMAL, M_AFTER: begin
        mode_next = M_NORMAL;
        if (c == CH_HASH) begin
          mode_next = M_PRE;
          if (prev != CH_NUL && prev != CH_LF) begin
            n_emit = 2'd2;
            b1     = CH_LF;
          end else begin
            n_emit = 2'd1;
          end
        end else if (is_blank(c) && !wants_space(prev)) begin
          n_emit = 2'd0;
        end else if (is_blank(prev) && !wants_space(c)) begin
          retract = held_valid && is_blank(held_char);
          n_emit  = 2'd1;
        end else if (mode == M_NORMAL && prev == CH_SLASH && c == CH_SLASH) begin
          retract   = 1'b1;
          mode_next = M_LINE;
        end else if (mode == M_NORMAL && prev == CH_SLASH && c == CH_STAR) begin
          retract   = 1'b1;
          mode_next = M_BLOCK;
        end else begin
          n_emit = 2'd1;
        end
      end
      default: mode_next = M_NORMAL;
    endcase
  end

  // order the results of this byte: displaced held byte, inserted newline, final flush
  always_comb begin
    hv_kept         = held_valid && !retract;
    cnt_new         = '0;
    held_char_next  = held_char;
    held_valid_next = hv_kept;
    for (int i = 0; i < RES_MAX; i++) res_new[i] = '{ch: c, last: 1'b0};
    if (n_emit != 2'd0 && hv_kept) begin
      res_new[cnt_new[IDX_W-1:0]] = '{ch: held_char, last: 1'b0};
      cnt_new = cnt_new + 1'b1;
    end
    if (n_emit == 2'd2) begin
      res_new[cnt_new[IDX_W-1:0]] = '{ch: b1, last: 1'b0};
      cnt_new = cnt_new + 1'b1;
      held_char_next  = b2;
      held_valid_next = 1'b1;
    end else if (n_emit == 2'd1) begin
      held_char_next  = b1;
      held_valid_next = 1'b1;
    end
    if (src.in_end && held_valid_next) begin
      res_new[cnt_new[IDX_W-1:0]] = '{ch: held_char_next, last: 1'b1};
      cnt_new = cnt_new + 1'b1;
    end
  end

  // take a byte only when the buffer is empty by the end of this cycle
  assign pop       = dst.valid && dst.ready;
  assign src.ready = (cnt == '0) || (cnt == CNT_W'(1) && dst.ready);
  assign accept    = src.valid && src.ready;

  assign dst.valid    = (cnt != '0);
  assign dst.out_char = res[0].ch;
  assign dst.out_end  = res[0].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_NORMAL;
      prev       <= CH_NUL;
      held_char  <= CH_NUL;
      held_valid <= 1'b0;
      cnt        <= '0;
    end else if (accept) begin
      cnt <= cnt_new;
      if (src.in_end) begin
        mode       <= M_NORMAL;
        prev       <= CH_NUL;
        held_char  <= CH_NUL;
        held_valid <= 1'b0;
      end else begin
        mode       <= mode_next;
        prev       <= c;
        held_char  <= held_char_next;
        held_valid <= held_valid_next;
      end
    end else if (pop) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_new;
    end else if (pop) begin
      for (int i = 0; i < RES_MAX - 1; i++) res[i] <= res[i+1];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ssm_checker.sv =====
`default_nettype none
`include "shader_source_minifier_macros.svh"

module ssm_checker import ssm_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_char,
  input logic              out_end
);

  // no result is offered straight after reset
  `SSM_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !out_valid, "result offered after reset")

  // a stalled result blocks the input side
  `SSM_ASSERT(a_stall_blocks_input, (out_valid && !out_ready) |-> !in_ready, "input taken while output stalled")

  `SSM_ASSERT(a_out_valid_holds, (out_valid && !out_ready) |=> out_valid, "result withdrawn while stalled")

  `SSM_ASSERT(a_out_data_holds, (out_valid && !out_ready) |=> ($stable(out_char) && $stable(out_end)), "stalled result changed")

endmodule

bind shader_source_minifier ssm_checker u_ssm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (src.valid),
  .in_ready  (src.ready),
  .out_valid (dst.valid),
  .out_ready (dst.ready),
  .out_char  (dst.out_char),
  .out_end   (dst.out_end)
);

`default_nettype wire
